### hw/rtl/bvrc_pkg.sv
// Shared types and constants for the bounded packed list block.
// Opcode and status codes, fixed field widths and register reset value.
// No dependencies.
`default_nettype none

package bvrc_pkg;

    // Fixed field widths
    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 8;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    // Capacity limit register reset value
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 9'd256;

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND  = 3'd0,
        OP_READ    = 3'd1,
        OP_REMOVE  = 3'd2,
        OP_MARK    = 3'd3,
        OP_COMPACT = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

endpackage

`default_nettype wire

### hw/rtl/bvrc_if.sv
// Channel interfaces of the bounded packed list: request, response and
// capacity-limit configuration. Depends on bvrc_pkg.
`default_nettype none

interface bvrc_req_if;
    import bvrc_pkg::*;
    logic                        valid;
    logic                        ready;
    logic [OPCODE_W-1:0]         opcode;
    logic signed [VALUE_W-1:0]   value;
    logic [INDEX_W-1:0]          index;

    modport source (output valid, opcode, value, index, input ready);
    modport sink   (input valid, opcode, value, index, output ready);
endinterface

interface bvrc_rsp_if;
    import bvrc_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [VALUE_W-1:0]   read_value;
    logic [COUNT_W-1:0]          count;
    logic [STATUS_W-1:0]         status;

    modport source (output valid, read_value, count, status, input ready);
    modport sink   (input valid, read_value, count, status, output ready);
endinterface

interface bvrc_cfg_if;
    import bvrc_pkg::*;
    logic                        valid;
    logic                        ready;
    logic [COUNT_W-1:0]          data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/bounded_vector_remove_compact.sv
// Top level of the bounded packed list of signed 32-bit integers.
// Depends on bvrc_pkg and the channel interfaces in bvrc_if.sv.
//
// Usage:
//   req carries one operation per beat (append, read, remove, mark, compact);
//   rsp returns exactly one beat per request: read data, element count after
//   the operation and a status code. cfg writes the capacity limit and is
//   always ready; write it only while no request is in flight.
// Sequencing (one request at a time):
//   append, mark, errors: straight from decode to the response hold state.
//   read: passes through a read state for the synchronous memory read.
//   remove at i shifts the entries above i down; compact walks the list. The walk
//   moves one entry per cycle through the single read and write port of the
//   element and mark memories.
// A new request is taken as soon as the previous one has finished, even if
// its response still sits in the output register.
// Reset empties the list (count zero) and sets the limit to 256; no memory
// clearing pass is needed. If rsp stalls, the finished result waits in a
// hold state and no further request is taken until the output frees up.
`default_nettype none

module bounded_vector_remove_compact #(
    parameter int CAPACITY = 256
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bvrc_cfg_if.sink   cfg,
    bvrc_req_if.sink   req,
    bvrc_rsp_if.source rsp
);
    import bvrc_pkg::*;

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = ($clog2(CAPACITY + 1) > COUNT_W) ? $clog2(CAPACITY + 1) : COUNT_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_WALK = 4'b0100,
        S_RESP = 4'b1000
    } state_t;

    // Element and mark memories
    logic [VALUE_W-1:0] val_mem  [CAPACITY];
    logic               mark_mem [CAPACITY];
    logic [VALUE_W-1:0] val_rd_reg;
    logic               mark_rd_reg;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               val_we;
    logic               mark_we;
    logic [VALUE_W-1:0] wr_val;
    logic               wr_mark;

    // Control and result registers
    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  limit_reg;
    logic [COUNT_W-1:0]  ptr_reg, ptr_next;
    logic [COUNT_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic                is_compact_reg, is_compact_next;
    logic [VALUE_W-1:0]  res_value_reg, res_value_next;
    status_t             res_status_reg, res_status_next;

    logic                out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]  out_value_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    status_t             out_status_reg;

    logic               accept;
    logic [COUNT_W-1:0] idx_ext;
    logic               idx_bad;
    logic               list_full;
    logic               out_free;
    logic               walk_more;
    logic               keep;
    logic               out_load;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;

    assign idx_ext   = COUNT_W'(req.index);
    assign idx_bad   = (idx_ext >= count_reg);
    assign list_full = (CMP_W'(count_reg) >= CMP_W'(limit_reg))
                    || (CMP_W'(count_reg) >= CMP_W'(CAPACITY));
    assign out_free  = !out_valid_reg || rsp.ready;
    assign walk_more = (ptr_reg < count_reg);
    assign keep      = is_compact_reg ? !mark_rd_reg : 1'b1;
    assign out_load  = (state_reg == S_RESP) && out_free;

    // Memories: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[wr_addr] <= wr_val;
        end
        if (mark_we)
        begin
            mark_mem[wr_addr] <= wr_mark;
        end
        if (rd_en)
        begin
            val_rd_reg  <= val_mem[rd_addr];
            mark_rd_reg <= mark_mem[rd_addr];
        end
    end

    // Sequencer: decode, memory walk, result hold
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        is_compact_next = is_compact_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        rd_en           = 1'b0;
        rd_addr         = AW'(ptr_reg);
        val_we          = 1'b0;
        mark_we         = 1'b0;
        wr_addr         = AW'(wr_ptr_reg);
        wr_val          = val_rd_reg;
        wr_mark         = mark_rd_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_value_next  = '0;
                    res_status_next = ST_OK;
                    state_next      = S_RESP;
                    case (req.opcode)
                        OP_APPEND:
                        begin
                            if (list_full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                val_we     = 1'b1;
                                mark_we    = 1'b1;
                                wr_addr    = AW'(count_reg);
                                wr_val     = req.value;
                                wr_mark    = 1'b0;
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        OP_READ:
                        begin
                            if (idx_bad)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(req.index);
                                state_next = S_READ;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (idx_bad)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else if ((idx_ext + COUNT_W'(1)) < count_reg)
                            begin
                                // shift entries above the index down by one
                                rd_en           = 1'b1;
                                rd_addr         = AW'(idx_ext + COUNT_W'(1));
                                ptr_next        = idx_ext + COUNT_W'(2);
                                wr_ptr_next     = idx_ext;
                                is_compact_next = 1'b0;
                                state_next      = S_WALK;
                            end
                            else
                            begin
                                // top entry: nothing to shift
                                count_next = count_reg - COUNT_W'(1);
                            end
                        end
                        OP_MARK:
                        begin
                            if (idx_bad)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                mark_we = 1'b1;
                                wr_addr = AW'(req.index);
                                wr_mark = 1'b1;
                            end
                        end
                        OP_COMPACT:
                        begin
                            if (count_reg != '0)
                            begin
                                rd_en           = 1'b1;
                                rd_addr         = '0;
                                ptr_next        = COUNT_W'(1);
                                wr_ptr_next     = '0;
                                is_compact_next = 1'b1;
                                state_next      = S_WALK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_value_next = val_rd_reg;
                state_next     = S_RESP;
            end
            S_WALK:
            begin
                // write back the entry read last cycle; compaction drops marked ones
                if (keep)
                begin
                    val_we      = 1'b1;
                    mark_we     = 1'b1;
                    wr_addr     = AW'(wr_ptr_reg);
                    wr_val      = val_rd_reg;
                    wr_mark     = is_compact_reg ? 1'b0 : mark_rd_reg;
                    wr_ptr_next = wr_ptr_reg + COUNT_W'(1);
                end
                if (walk_more)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(ptr_reg);
                    ptr_next = ptr_reg + COUNT_W'(1);
                end
                else
                begin
                    state_next = S_RESP;
                    if (is_compact_reg)
                    begin
                        count_next = keep ? (wr_ptr_reg + COUNT_W'(1)) : wr_ptr_reg;
                    end
                    else
                    begin
                        count_next = count_reg - COUNT_W'(1);
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capacity limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            limit_reg <= cfg.data;
        end
    end

    // Walk pointers and result payload
    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        wr_ptr_reg     <= wr_ptr_next;
        is_compact_reg <= is_compact_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_count_reg  <= count_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = out_value_reg;
    assign rsp.count      = out_count_reg;
    assign rsp.status     = out_status_reg;

    // Checks
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(CAPACITY))
        else $error("element count above capacity");

    a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (wr_ptr_reg < ptr_reg))
        else $error("walk write pointer caught up with read pointer");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != S_IDLE))
        else $error("request taken without leaving idle");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_FULL)) |->
            ((CMP_W'(out_count_reg) >= CMP_W'(limit_reg))
             || (CMP_W'(out_count_reg) >= CMP_W'(CAPACITY))))
        else $error("full status with room left");

endmodule

`default_nettype wire
